FILE: design/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg: shared types, constants and arithmetic for the spring-damper block
// Q16.16 word sizes, register indexes, reset values and the saturating
// fixed-point multiply and clamp used by the force pipeline.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int W    = 32;        // word width of fields and registers
    localparam int F    = 16;        // fractional bits
    localparam int DW   = W + 1;     // exact coordinate difference
    localparam int SQW  = 2 * DW;    // sum of squares
    localparam int RTW  = DW;        // square root width
    localparam int RMW  = DW + 2;    // square root remainder
    localparam int QW   = F + 1;     // unit direction magnitude
    localparam int DIRW = F + 2;     // signed direction component
    localparam int MW   = W + 4;     // operand width of the Q multiply

    localparam logic [1:0] REG_STIFFNESS   = 2'd0;
    localparam logic [1:0] REG_DAMPING     = 2'd1;
    localparam logic [1:0] REG_NATURAL_LEN = 2'd2;
    localparam logic [1:0] REG_INIT_DIST   = 2'd3;

    localparam logic [W-1:0] STIFFNESS_RST   = 32'd6553600;
    localparam logic [W-1:0] DAMPING_RST     = 32'd655360;
    localparam logic [W-1:0] NATURAL_LEN_RST = 32'hFFFF_0000;
    localparam logic [W-2:0] INIT_DIST_RST   = '0;

    localparam logic signed [DIRW-1:0] ONE_Q = DIRW'(1) << F;

    localparam logic signed [MW-1:0] QMAX = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [MW-1:0] QMIN = {{(MW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][DW-1:0]  ad;
        logic [2:0][DW-1:0]  vrel;
    } side_t;

    typedef struct packed {
        logic [W-1:0]        stiffness;
        logic [W-1:0]        damping;
        logic [W-1:0]        natural_len;
        logic [W-2:0]        initial_distance;
    } cfg_t;

    typedef struct packed {
        logic signed [W-1:0] v;
        logic                sat;
    } qres_t;

    // Exact product of two Q values, truncated toward zero, clamped to a word.
    function automatic qres_t mulq(input logic signed [MW-1:0] a,
                                   input logic signed [MW-1:0] b);
        logic              neg;
        logic [MW-1:0]     ma;
        logic [MW-1:0]     mb;
        logic [2*MW-1:0]   p;
        logic [2*MW-1:0]   sh;
        logic [2*MW-1:0]   lim;
        qres_t             r;
        neg = a[MW-1] ^ b[MW-1];
        ma  = a[MW-1] ? MW'(-a) : MW'(a);
        mb  = b[MW-1] ? MW'(-b) : MW'(b);
        p   = (2*MW)'(ma) * (2*MW)'(mb);
        sh  = p >> F;
        lim = ((2*MW)'(1) << (W - 1)) - (neg ? (2*MW)'(0) : (2*MW)'(1));
        r.sat = 1'b0;
        if (sh > lim)
        begin
            r.sat = 1'b1;
            sh    = lim;
        end
        r.v = neg ? W'(-sh) : W'(sh);
        return r;
    endfunction

    function automatic qres_t clampw(input logic signed [MW-1:0] x);
        qres_t r;
        r.sat = 1'b0;
        r.v   = W'(x);
        if (x > QMAX)
        begin
            r.sat = 1'b1;
            r.v   = W'(QMAX);
        end
        else if (x < QMIN)
        begin
            r.sat = 1'b1;
            r.v   = W'(QMIN);
        end
        return r;
    endfunction

endpackage

FILE: design/sdf_pair_if.sv
// ----------------------------------------------------------------------------
// sdf_pair_if: input channel carrying one body pair
// Positions and linear velocities of bodies A and B with valid/ready.
// ----------------------------------------------------------------------------
interface sdf_pair_if import sdf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pos_a_x;
    logic signed [W-1:0] pos_a_y;
    logic signed [W-1:0] pos_a_z;
    logic signed [W-1:0] pos_b_x;
    logic signed [W-1:0] pos_b_y;
    logic signed [W-1:0] pos_b_z;
    logic signed [W-1:0] vel_a_x;
    logic signed [W-1:0] vel_a_y;
    logic signed [W-1:0] vel_a_z;
    logic signed [W-1:0] vel_b_x;
    logic signed [W-1:0] vel_b_y;
    logic signed [W-1:0] vel_b_z;

    modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                    vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, input ready);
    modport sink   (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                    vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, output ready);
endinterface

FILE: design/sdf_result_if.sv
// ----------------------------------------------------------------------------
// sdf_result_if: output channel carrying one force result
// Force on body A with coincident and saturated flags, valid/ready.
// ----------------------------------------------------------------------------
interface sdf_result_if import sdf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] force_x;
    logic signed [W-1:0] force_y;
    logic signed [W-1:0] force_z;
    logic                coincident;
    logic                saturated;

    modport source (output valid, force_x, force_y, force_z, coincident, saturated,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, coincident, saturated,
                    output ready);
endinterface

FILE: design/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front: difference and sum-of-squares stages
// Three registered stages: differences, squares, sum of squares.
// ----------------------------------------------------------------------------
module sdf_front import sdf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             v_in,
    input  logic [2:0][W-1:0] pa,
    input  logic [2:0][W-1:0] pb,
    input  logic [2:0][W-1:0] va,
    input  logic [2:0][W-1:0] vb,
    output logic             v_out,
    output logic [SQW-1:0]   s_out,
    output side_t            side_out
);

    logic [2:0]            vld_reg;
    side_t                 side1_next;
    side_t                 side1_reg;
    side_t                 side2_reg;
    logic [2:0][SQW-1:0]   sq_reg;
    logic [SQW-1:0]        s_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [DW-1:0] d;
            d = DW'($signed(pb[i])) - DW'($signed(pa[i]));
            side1_next.neg[i]  = d[DW-1];
            side1_next.ad[i]   = d[DW-1] ? DW'(-d) : DW'(d);
            side1_next.vrel[i] = DW'($signed(vb[i])) - DW'($signed(va[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], v_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side_out  <= side2_reg;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SQW'(side1_reg.ad[i]) * SQW'(side1_reg.ad[i]);
            s_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign v_out = vld_reg[2];
    assign s_out = s_reg;

endmodule

FILE: design/sdf_sqrt.sv
// ----------------------------------------------------------------------------
// sdf_sqrt: pipelined floor square root
// One result bit per stage, two radicand bits consumed per stage.
// ----------------------------------------------------------------------------
module sdf_sqrt import sdf_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           v_in,
    input  logic [SQW-1:0] s_in,
    input  side_t          side_in,
    output logic           v_out,
    output logic [RTW-1:0] root,
    output side_t          side_out
);

    logic [RTW-1:0]            vld_reg;
    logic [RTW-1:0][RTW-1:0]   root_reg;
    logic [RTW-1:0][RMW-1:0]   rem_reg;
    logic [RTW-1:0][SQW-1:0]   s_reg;
    side_t                     side_reg [RTW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RTW-2:0], v_in};
    end

    for (genvar k = 0; k < RTW; k++)
    begin : g_stage
        logic [RTW-1:0] root_p;
        logic [RMW-1:0] rem_p;
        logic [SQW-1:0] s_p;
        side_t          side_p;
        logic [RMW+1:0] rem_sh;
        logic [RMW+1:0] trial;
        logic           take;

        if (k == 0)
        begin : g_first
            assign root_p = '0;
            assign rem_p  = '0;
            assign s_p    = s_in;
            assign side_p = side_in;
        end
        else
        begin : g_next
            assign root_p = root_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign s_p    = s_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        assign rem_sh = {rem_p, s_p[2*(RTW-1-k)+1 -: 2]};
        assign trial  = (RMW+2)'({root_p, 2'b01});
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_p[RTW-2:0], take};
                rem_reg[k]  <= take ? RMW'(rem_sh - trial) : RMW'(rem_sh);
                s_reg[k]    <= s_p;
                side_reg[k] <= side_p;
            end
        end
    end

    assign v_out    = vld_reg[RTW-1];
    assign root     = root_reg[RTW-1];
    assign side_out = side_reg[RTW-1];

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_out |-> (SQW+2)'(root) * (SQW+2)'(root) <= (SQW+2)'(s_reg[RTW-1])
               && ((SQW+2)'(root) + 1) * ((SQW+2)'(root) + 1) > (SQW+2)'(s_reg[RTW-1]))
        else $error("square root stage result is not the floor root");

endmodule

FILE: design/sdf_div.sv
// ----------------------------------------------------------------------------
// sdf_div: pipelined unit-direction divider
// Three restoring-division lanes form |d| * 2^F / distance, one bit a stage.
// ----------------------------------------------------------------------------
module sdf_div import sdf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                v_in,
    input  logic [DW-1:0]       dist_in,
    input  side_t               side_in,
    output logic                v_out,
    output logic [DW-1:0]       dist_out,
    output logic [2:0][QW-1:0]  q_out,
    output side_t               side_out
);

    logic [QW-1:0]                  vld_reg;
    logic [QW-1:0][DW-1:0]          den_reg;
    logic [QW-1:0][2:0][DW-1:0]     r_reg;
    logic [QW-1:0][2:0][QW-1:0]     q_reg;
    side_t                          side_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QW-2:0], v_in};
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0]          den_p;
        side_t                  side_p;
        logic [2:0][DW-1:0]     r_n;
        logic [2:0][QW-1:0]     q_n;

        if (k == 0)
        begin : g_first
            assign den_p  = dist_in;
            assign side_p = side_in;
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic ge;
                    ge     = (side_in.ad[i] >= dist_in);
                    r_n[i] = ge ? DW'(side_in.ad[i] - dist_in) : side_in.ad[i];
                    q_n[i] = QW'(ge);
                end
            end
        end
        else
        begin : g_next
            assign den_p  = den_reg[k-1];
            assign side_p = side_reg[k-1];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic [DW:0] r2;
                    logic        ge;
                    r2     = {r_reg[k-1][i], 1'b0};
                    ge     = (r2 >= {1'b0, den_reg[k-1]});
                    r_n[i] = ge ? DW'(r2 - {1'b0, den_reg[k-1]}) : DW'(r2);
                    q_n[i] = {q_reg[k-1][i][QW-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]  <= den_p;
                side_reg[k] <= side_p;
                r_reg[k]    <= r_n;
                q_reg[k]    <= q_n;
            end
        end
    end

    assign v_out    = vld_reg[QW-1];
    assign dist_out = den_reg[QW-1];
    assign q_out    = q_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

FILE: design/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back: force magnitude and projection stages
// Direction, spring and velocity products, damping, magnitude and force;
// the last stage is the output register.
// ----------------------------------------------------------------------------
module sdf_back import sdf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                v_in,
    input  logic [DW-1:0]       span,
    input  logic [2:0][QW-1:0]  q,
    input  side_t               side,
    input  cfg_t                cfg,
    output logic                v_out,
    output logic [2:0][W-1:0]   force_out,
    output logic                coinc_out,
    output logic                sat_out
);

    logic [5:0]                 vld_reg;

    // Stage 1: direction and stretch.
    logic [2:0][DIRW-1:0]       dir1_reg;
    logic [2:0][DW-1:0]         vrel1_reg;
    logic signed [MW-1:0]       stretch1_reg;
    logic                       coinc1_reg;
    // Stage 2: products.
    logic [2:0][DIRW-1:0]       dir2_reg;
    logic [2:0][W-1:0]          pv2_reg;
    logic signed [W-1:0]        spring2_reg;
    logic                       sat2_reg;
    logic                       coinc2_reg;
    // Stage 3: projected velocity.
    logic [2:0][DIRW-1:0]       dir3_reg;
    logic signed [W-1:0]        dot3_reg;
    logic signed [W-1:0]        spring3_reg;
    logic                       sat3_reg;
    logic                       coinc3_reg;
    // Stage 4: damping term.
    logic [2:0][DIRW-1:0]       dir4_reg;
    logic signed [W-1:0]        damp4_reg;
    logic signed [W-1:0]        spring4_reg;
    logic                       sat4_reg;
    logic                       coinc4_reg;
    // Stage 5: magnitude.
    logic [2:0][DIRW-1:0]       dir5_reg;
    logic signed [W-1:0]        mag5_reg;
    logic                       sat5_reg;
    logic                       coinc5_reg;
    // Stage 6: output.
    logic [2:0][W-1:0]          force6_reg;
    logic                       sat6_reg;
    logic                       coinc6_reg;

    logic [2:0][DIRW-1:0]       dir1_next;
    logic signed [MW-1:0]       stretch1_next;
    qres_t [2:0]                pv2_next;
    qres_t                      spring2_next;
    qres_t                      dot3_next;
    qres_t                      damp4_next;
    qres_t                      mag5_next;
    qres_t [2:0]                force6_next;

    always_comb
    begin
        logic coinc;
        logic signed [MW-1:0] rest;
        coinc = (span == '0);
        for (int i = 0; i < 3; i++)
        begin
            if (coinc)
                dir1_next[i] = (i == 0) ? ONE_Q : '0;
            else if (side.neg[i])
                dir1_next[i] = DIRW'(-$signed({1'b0, q[i]}));
            else
                dir1_next[i] = DIRW'({1'b0, q[i]});
        end
        // A negative rest length selects the software-written initial distance.
        rest = cfg.natural_len[W-1] ? MW'(cfg.initial_distance) : MW'(cfg.natural_len);
        stretch1_next = MW'(span) - rest;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            pv2_next[i] = mulq(MW'($signed(vrel1_reg[i])), MW'($signed(dir1_reg[i])));
        spring2_next = mulq(MW'(cfg.stiffness), stretch1_reg);
        dot3_next = clampw(MW'($signed(pv2_reg[0])) + MW'($signed(pv2_reg[1]))
                           + MW'($signed(pv2_reg[2])));
        damp4_next = mulq(MW'(cfg.damping), MW'(dot3_reg));
        mag5_next  = clampw(MW'(spring4_reg) + MW'(damp4_reg));
        for (int i = 0; i < 3; i++)
            force6_next[i] = mulq(MW'(mag5_reg), MW'($signed(dir5_reg[i])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], v_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir1_reg     <= dir1_next;
            vrel1_reg    <= side.vrel;
            stretch1_reg <= stretch1_next;
            coinc1_reg   <= (span == '0);

            dir2_reg    <= dir1_reg;
            for (int i = 0; i < 3; i++)
                pv2_reg[i] <= pv2_next[i].v;
            spring2_reg <= spring2_next.v;
            sat2_reg    <= pv2_next[0].sat | pv2_next[1].sat | pv2_next[2].sat
                           | spring2_next.sat;
            coinc2_reg  <= coinc1_reg;

            dir3_reg    <= dir2_reg;
            dot3_reg    <= dot3_next.v;
            spring3_reg <= spring2_reg;
            sat3_reg    <= sat2_reg | dot3_next.sat;
            coinc3_reg  <= coinc2_reg;

            dir4_reg    <= dir3_reg;
            damp4_reg   <= damp4_next.v;
            spring4_reg <= spring3_reg;
            sat4_reg    <= sat3_reg | damp4_next.sat;
            coinc4_reg  <= coinc3_reg;

            dir5_reg    <= dir4_reg;
            mag5_reg    <= mag5_next.v;
            sat5_reg    <= sat4_reg | mag5_next.sat;
            coinc5_reg  <= coinc4_reg;

            for (int i = 0; i < 3; i++)
                force6_reg[i] <= force6_next[i].v;
            sat6_reg   <= sat5_reg | force6_next[0].sat | force6_next[1].sat
                          | force6_next[2].sat;
            coinc6_reg <= coinc5_reg;
        end
    end

    assign v_out     = vld_reg[5];
    assign force_out = force6_reg;
    assign coinc_out = coinc6_reg;
    assign sat_out   = sat6_reg;

    a_coinc_axis: assert property (@(posedge clk) disable iff (!rst_n)
        v_out && coinc_out |-> force_out[1] == '0 && force_out[2] == '0)
        else $error("coincident result has force off the x axis");

endmodule

FILE: design/spring_damper_force_top.sv
// ----------------------------------------------------------------------------
// spring_damper_force_top: linear spring-damper force between two bodies
// Streams body pairs in Q16.16 and returns the saturating force on body A.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : valid/ready input, one transfer per body pair (positions and
//            linear velocities of bodies A and B).
//   result : valid/ready output, one transfer per pair, in order: force on A
//            (negate for B), a coincident flag and a saturated flag.
//   cfg_*  : register writes (stiffness, damping, rest length, initial
//            distance), applied at the edge where cfg_we is high. Write only
//            while no pair is in flight.
// Throughput is one pair per clock while the receiver takes results. There are
// 59 register stages: 3 difference/square stages, 33 square root stages (one
// root bit each), 17 divider stages (one quotient bit each) and 6 force stages,
// the last of which is the output register.
// Reset empties the pipeline and loads the default registers (stiffness 100,
// damping 10, rest length -1 so the initial distance is used).
// When the receiver stalls the whole pipeline holds; pair.ready drops only
// while a result is held in the output register and not taken.
// ----------------------------------------------------------------------------
module spring_damper_force_top import sdf_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [W-1:0]  cfg_data,
    sdf_pair_if.sink      pair,
    sdf_result_if.source  result
);

    cfg_t                cfg_reg;
    logic                en;

    logic                f_valid;
    logic [SQW-1:0]      f_s;
    side_t               f_side;
    logic                r_valid;
    logic [RTW-1:0]      r_root;
    side_t               r_side;
    logic                d_valid;
    logic [DW-1:0]       d_dist;
    logic [2:0][QW-1:0]  d_q;
    side_t               d_side;
    logic [2:0][W-1:0]   force_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stiffness        <= STIFFNESS_RST;
            cfg_reg.damping          <= DAMPING_RST;
            cfg_reg.natural_len      <= NATURAL_LEN_RST;
            cfg_reg.initial_distance <= INIT_DIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STIFFNESS:   cfg_reg.stiffness        <= cfg_data;
                REG_DAMPING:     cfg_reg.damping          <= cfg_data;
                REG_NATURAL_LEN: cfg_reg.natural_len      <= cfg_data;
                REG_INIT_DIST:   cfg_reg.initial_distance <= cfg_data[W-2:0];
                default:         ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or drained.
    assign en         = !result.valid || result.ready;
    assign pair.ready = en;

    sdf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (pair.valid),
        .pa       ({pair.pos_a_z, pair.pos_a_y, pair.pos_a_x}),
        .pb       ({pair.pos_b_z, pair.pos_b_y, pair.pos_b_x}),
        .va       ({pair.vel_a_z, pair.vel_a_y, pair.vel_a_x}),
        .vb       ({pair.vel_b_z, pair.vel_b_y, pair.vel_b_x}),
        .v_out    (f_valid),
        .s_out    (f_s),
        .side_out (f_side)
    );

    sdf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (f_valid),
        .s_in     (f_s),
        .side_in  (f_side),
        .v_out    (r_valid),
        .root     (r_root),
        .side_out (r_side)
    );

    sdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (r_valid),
        .dist_in  (r_root),
        .side_in  (r_side),
        .v_out    (d_valid),
        .dist_out (d_dist),
        .q_out    (d_q),
        .side_out (d_side)
    );

    sdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .v_in      (d_valid),
        .span      (d_dist),
        .q         (d_q),
        .side      (d_side),
        .cfg       (cfg_reg),
        .v_out     (result.valid),
        .force_out (force_w),
        .coinc_out (result.coincident),
        .sat_out   (result.saturated)
    );

    assign result.force_x = force_w[0];
    assign result.force_y = force_w[1];
    assign result.force_z = force_w[2];

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !pair.ready)
        else $error("input taken while the output register is stalled");

endmodule

FILE: dv/tb_spring_damper_force_top.sv
// ----------------------------------------------------------------------------
// tb_spring_damper_force_top: self-checking bench for the spring-damper block
// A short directed table runs first, then random body pairs under several
// register settings. An in-bench fixed-point model predicts each ungiven result, and
// results are checked in order as they leave the output channel.
// ----------------------------------------------------------------------------
module tb_spring_damper_force_top import sdf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 59;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 7;
    localparam int PER_PHASE   = 145;

    typedef logic [W-1:0] word_t;
    typedef word_t pair_fields_t [12];

    typedef struct {
        logic signed [W-1:0] fx;
        logic signed [W-1:0] fy;
        logic signed [W-1:0] fz;
        logic                coincident;
        logic                saturated;
    } force_t;

    typedef struct {
        pair_fields_t f;
        bit           typed;
        force_t       res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [W-1:0] cfg_data;

    sdf_pair_if   pair ();
    sdf_result_if result ();

    spring_damper_force_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pair      (pair.sink),
        .result    (result.source)
    );

    // Register shadow used by the force predictor.
    logic [W-1:0] k_spring;
    logic [W-1:0] k_damp;
    logic [W-1:0] rest_len;
    logic [W-2:0] init_dist;

    force_t expected_forces[$];
    int     n_fail;
    int     n_pairs;
    int     n_results;
    int     n_coincident;
    int     n_saturated;
    longint cycles;
    bit     quiet_send;
    bit     quiet_recv;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact product of two fixed-point values, truncated toward zero, clamped.
    function automatic longint fx_mul(input longint a, input longint b, inout bit sat);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        logic [127:0] lim;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? 128'(-a) : 128'(a);
        mb  = (b < 0) ? 128'(-b) : 128'(b);
        p   = (ma * mb) >> F;
        lim = neg ? (128'(1) << (W - 1)) : ((128'(1) << (W - 1)) - 1);
        if (p > lim)
        begin
            sat = 1'b1;
            p   = lim;
        end
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint fx_clamp(input longint x, inout bit sat);
        longint hi;
        longint lo;
        hi = (longint'(1) << (W - 1)) - 1;
        lo = -(longint'(1) << (W - 1));
        if (x > hi)
        begin
            sat = 1'b1;
            return hi;
        end
        if (x < lo)
        begin
            sat = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic force_t predict_force(input pair_fields_t f);
        longint       d[3];
        longint       vrel[3];
        longint       dir[3];
        longint       ad;
        logic [127:0] sumsq;
        logic [127:0] root;
        logic [127:0] trial;
        longint       span;
        longint       rest;
        longint       spring;
        longint       dot;
        longint       damp;
        longint       mag;
        bit           sat;
        force_t       r;
        sat   = 1'b0;
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]    = longint'($signed(f[3 + i])) - longint'($signed(f[i]));
            vrel[i] = longint'($signed(f[9 + i])) - longint'($signed(f[6 + i]));
            ad      = (d[i] < 0) ? -d[i] : d[i];
            sumsq   = sumsq + 128'(ad) * 128'(ad);
        end
        root = '0;
        for (int b = 40; b >= 0; b--)
        begin
            trial = root | (128'(1) << b);
            if (trial * trial <= sumsq)
                root = trial;
        end
        span = longint'(root);
        for (int i = 0; i < 3; i++)
        begin
            if (span == 0)
                dir[i] = (i == 0) ? (longint'(1) << F) : 0;
            else
            begin
                ad     = (d[i] < 0) ? -d[i] : d[i];
                dir[i] = (ad << F) / span;
                if (d[i] < 0)
                    dir[i] = -dir[i];
            end
        end
        rest   = $signed(rest_len) < 0 ? longint'(init_dist) : longint'($signed(rest_len));
        spring = fx_mul(longint'(k_spring), span - rest, sat);
        dot    = 0;
        for (int i = 0; i < 3; i++)
            dot += fx_mul(vrel[i], dir[i], sat);
        dot  = fx_clamp(dot, sat);
        damp = fx_mul(longint'(k_damp), dot, sat);
        mag  = fx_clamp(spring + damp, sat);
        r.fx = W'(fx_mul(mag, dir[0], sat));
        r.fy = W'(fx_mul(mag, dir[1], sat));
        r.fz = W'(fx_mul(mag, dir[2], sat));
        r.coincident = (span == 0);
        r.saturated  = sat;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_STIFFNESS:   k_spring  = value;
            REG_DAMPING:     k_damp    = value;
            REG_NATURAL_LEN: rest_len  = value;
            REG_INIT_DIST:   init_dist = value[W-2:0];
            default:         ;
        endcase
    endtask

    // Offers one pair, with random idle cycles in front unless quiet_send is set,
    // and records the expected result (given or predicted) once the transfer happens.
    task automatic send_pair(input pair_fields_t f, input bit typed, input force_t res);
        @(negedge clk);
        while (!quiet_send && $urandom_range(99) < 24)
        begin
            pair.valid = 1'b0;
            @(negedge clk);
        end
        pair.valid   = 1'b1;
        pair.pos_a_x = f[0];
        pair.pos_a_y = f[1];
        pair.pos_a_z = f[2];
        pair.pos_b_x = f[3];
        pair.pos_b_y = f[4];
        pair.pos_b_z = f[5];
        pair.vel_a_x = f[6];
        pair.vel_a_y = f[7];
        pair.vel_a_z = f[8];
        pair.vel_b_x = f[9];
        pair.vel_b_y = f[10];
        pair.vel_b_z = f[11];
        do
            @(posedge clk);
        while (!pair.ready);
        expected_forces.push_back(typed ? res : predict_force(f));
        n_pairs++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        pair.valid = 1'b0;
        while (expected_forces.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic word_t rand_word(input int mode);
        case (mode)
            0: return $urandom();
            1: return word_t'($signed($urandom_range(1 << 20, 0)) - (1 << 19));
            default: return word_t'($signed($urandom_range(1 << 24, 0)) - (1 << 23));
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (quiet_recv)
            result.ready <= 1'b1;
        else
            result.ready <= ($urandom_range(99) >= 24);
    end

    always @(posedge clk)
    begin
        force_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("result transfer with no pair outstanding");
                n_fail++;
            end
            else
            begin
                want = expected_forces.pop_front();
                n_results++;
                if (result.coincident)
                    n_coincident++;
                if (result.saturated)
                    n_saturated++;
                if (result.force_x !== want.fx)
                begin
                    $error("force_x expected %0d got %0d", want.fx, result.force_x);
                    n_fail++;
                end
                if (result.force_y !== want.fy)
                begin
                    $error("force_y expected %0d got %0d", want.fy, result.force_y);
                    n_fail++;
                end
                if (result.force_z !== want.fz)
                begin
                    $error("force_z expected %0d got %0d", want.fz, result.force_z);
                    n_fail++;
                end
                if (result.coincident !== want.coincident)
                begin
                    $error("coincident expected %0b got %0b", want.coincident,
                           result.coincident);
                    n_fail++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated expected %0b got %0b", want.saturated,
                           result.saturated);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        stim_row_t    dir_rows[$];
        stim_row_t    row;
        pair_fields_t f;
        force_t       none;
        int           mode;
        logic [W-1:0] setting[N_PHASES][4];

        n_fail       = 0;
        n_pairs      = 0;
        n_results    = 0;
        n_coincident = 0;
        n_saturated  = 0;
        cycles       = 0;
        quiet_send   = 1'b0;
        quiet_recv   = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_STIFFNESS;
        cfg_data     = '0;
        pair.valid   = 1'b0;
        {pair.pos_a_x, pair.pos_a_y, pair.pos_a_z} = '0;
        {pair.pos_b_x, pair.pos_b_y, pair.pos_b_z} = '0;
        {pair.vel_a_x, pair.vel_a_y, pair.vel_a_z} = '0;
        {pair.vel_b_x, pair.vel_b_y, pair.vel_b_z} = '0;
        result.ready = 1'b0;
        k_spring  = STIFFNESS_RST;
        k_damp    = DAMPING_RST;
        rest_len  = NATURAL_LEN_RST;
        init_dist = INIT_DIST_RST;
        none      = '{0, 0, 0, 1'b0, 1'b0};

        // Directed rows run with the reset register values.
        row.f = '{default: '0};
        row.typed = 1'b1;
        row.res = '{0, 0, 0, 1'b1, 1'b0};
        dir_rows.push_back(row);
        row.f[3] = 32'h0001_0000;
        row.res = '{32'd6553600, 0, 0, 1'b0, 1'b0};
        dir_rows.push_back(row);
        row.f = '{default: '0};
        row.f[9] = 32'h0001_0000;
        row.res = '{32'd655360, 0, 0, 1'b1, 1'b0};
        dir_rows.push_back(row);
        row.typed = 1'b0;
        row.res = none;
        row.f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        dir_rows.push_back(row);
        row.f = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        dir_rows.push_back(row);
        row.f = '{default: 32'hffff_ffff};
        dir_rows.push_back(row);
        row.f = '{0, 0, 0, 0, 32'hfffe_0000, 0, 0, 0, 0, 0, 32'h0003_0000, 0};
        dir_rows.push_back(row);
        row.f = '{0, 0, 0, 0, 0, 32'h0002_8000, 0, 0, 0, 0, 0, 32'hffff_0000};
        dir_rows.push_back(row);
        row.f = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                  32'h0002_0000, 32'h0002_0000, 32'h0000_8000, 0, 0, 0, 0, 32'h0000_8000};
        dir_rows.push_back(row);
        row.f = '{0, 0, 0, 32'h0000_0001, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_rows.push_back(row);
        row.f = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                  32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                  32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
        dir_rows.push_back(row);

        // Register settings per random phase: stiffness, damping, rest length,
        // initial distance. The first keeps the reset values.
        setting[0] = '{STIFFNESS_RST, DAMPING_RST, NATURAL_LEN_RST, 32'd0};
        setting[1] = '{32'd0, 32'd0, 32'h0003_0000, 32'h7fff_ffff};
        setting[2] = '{32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff};
        setting[3] = '{32'h0000_8000, 32'h0001_0000, 32'h7fff_ffff, 32'h0002_0000};
        setting[4] = '{32'h0002_0000, 32'h0000_4000, 32'hffff_ffff, 32'h0004_8000};
        setting[5] = '{32'h00c8_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001};
        setting[6] = '{32'h0000_0001, 32'h0014_0000, 32'h0001_8000, 32'h2aaa_aaaa};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_pair(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
                for (int r = 0; r < 4; r++)
                    write_reg(r[1:0], setting[ph][r]);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                // Phase 2 runs with no idle cycles on either side.
                quiet_send = (ph == 2);
                quiet_recv = (ph == 2) || (ph == 3);
                // Mostly bodies near each other, so the force stays in range.
                mode = ($urandom_range(9) < 2) ? 0 : (($urandom_range(1)) ? 1 : 2);
                for (int k = 0; k < 12; k++)
                    f[k] = rand_word(mode);
                if ($urandom_range(19) == 0)
                    for (int k = 0; k < 3; k++)
                        f[3 + k] = f[k];
                send_pair(f, 1'b0, none);
            end
            quiet_send = 1'b0;
            quiet_recv = 1'b0;
            drain_results();
        end

        $display("Ran %0d pairs over %0d register settings; %0d results checked.",
                 n_pairs, N_PHASES, n_results);
        $display("Results with coincident bodies: %0d, with saturation: %0d.",
                 n_coincident, n_saturated);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
